@@ sv/mtfc_pkg.sv @@
// Package with the shared types and constants of the move-to-front codec.
package mtfc_pkg;

  // Width of a symbol or a table position.
  localparam int unsigned SYM_W = 8;

  // The reduction tree always spans the full byte range.
  localparam int unsigned LEAVES = 256;
  localparam int unsigned LEVELS = 8;

  // Value given for an encoded symbol that is not in the table.
  localparam logic [SYM_W-1:0] NO_MATCH = 8'hFF;

  // Register indexes on the configuration port.
  localparam logic REG_MODE = 1'b0;

  // Mode register codes.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Control that the sequencer broadcasts to every cell.
  typedef struct packed {
    logic             dec;       // decode lookup rather than encode
    logic [SYM_W-1:0] key;       // symbol to find, or clamped position
    logic             update;    // perform the move to front
    logic [SYM_W-1:0] pos;       // position of the entry being moved
    logic             identity;  // return the table to identity order
  } mtfc_ctrl_t;

  // One leaf or node of the lookup reduction.
  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] val;
  } mtfc_leaf_t;

endpackage

@@ sv/mtfc_if.sv @@
// Valid/ready channel interfaces for the input and result items.
interface mtfc_in_if import mtfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] data_in;
  logic             end_of_block;

  modport source (output valid, output data_in, output end_of_block, input ready);
  modport sink (input valid, input data_in, input end_of_block, output ready);
endinterface

interface mtfc_out_if import mtfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] data_out;
  logic             last_out;

  modport source (output valid, output data_out, output last_out, input ready);
  modport sink (input valid, input data_out, input last_out, output ready);
endinterface

@@ sv/mtfc_cell.sv @@
// One table cell: holds a symbol, compares it and shifts from its neighbour.
module mtfc_cell import mtfc_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mtfc_ctrl_t       ctrl_i,
  input  logic [SYM_W-1:0] prev_i,
  output logic [SYM_W-1:0] sym_o,
  output mtfc_leaf_t       leaf_o
);

  localparam logic [SYM_W-1:0] Idx = SYM_W'(INDEX);

  logic [SYM_W-1:0] sym_q, sym_d;

  // Lookup: decode selects this cell by position, encode by its contents.
  always_comb begin
    if (ctrl_i.dec) begin
      leaf_o.hit = (Idx == ctrl_i.key);
      leaf_o.val = sym_q;
    end else begin
      leaf_o.hit = (sym_q == ctrl_i.key);
      leaf_o.val = Idx;
    end
  end

  // Cells at or ahead of the moved entry take their neighbour's symbol; identity restores the index.
  always_comb begin
    sym_d = sym_q;
    if (ctrl_i.identity) begin
      sym_d = Idx;
    end else if (ctrl_i.update && (Idx <= ctrl_i.pos)) begin
      sym_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= Idx;
    end else begin
      sym_q <= sym_d;
    end
  end

  assign sym_o = sym_q;

endmodule

@@ sv/mtfc_reduce.sv @@
// Registered pairwise reduction that finds the hitting cell, one level a cycle.
module mtfc_reduce import mtfc_pkg::*; (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       step_i,
  input  mtfc_leaf_t leaves_i [LEAVES],
  output mtfc_leaf_t root_o
);

  mtfc_leaf_t red_q [LEAVES];

  // Each step halves the number of live nodes; node 0 ends as the result.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < LEAVES; i++) begin
        red_q[i] <= leaves_i[i];
      end
    end else if (step_i) begin
      for (int j = 0; j < LEAVES / 2; j++) begin
        red_q[j] <= red_q[2*j].hit ? red_q[2*j] : red_q[2*j+1];
      end
    end
  end

  assign root_o = red_q[0];

endmodule

@@ sv/move_to_front_codec.sv @@
// Move-to-front codec top level: cell chain, lookup tree, sequencer and APB port.
// An accepted item is loaded into the 8-level registered lookup tree in the idle state,
// reduced level by level in the reduce state, then moved to the front and written out
// in the finish state. A new item is accepted only once the previous one has finished.
// A waiting result does not stop the next item from being accepted and looked up.
// Reset is asynchronous and active low; it sets the table to identity, mode to encode.
module move_to_front_codec import mtfc_pkg::*; #(
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtfc_in_if.sink     in_i,
  mtfc_out_if.source  out_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_FIN    = 2'd2;

  localparam logic [SYM_W-1:0] LastPos = SYM_W'(ALPHABET_SIZE - 1);
  localparam logic [SYM_W:0]   AlphaLen = (SYM_W+1)'(ALPHABET_SIZE);

  logic [1:0]       state_q, state_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             mode_q;
  logic             dec_q;
  logic [SYM_W-1:0] key_q;
  logic             eob_q;
  logic             out_valid_q;
  logic [SYM_W-1:0] data_out_q;
  logic             last_q;

  logic             accept;
  logic             finish;
  logic [SYM_W-1:0] key_in;
  mtfc_ctrl_t       ctrl;
  mtfc_leaf_t       root;
  mtfc_leaf_t       leaves [LEAVES];
  logic [SYM_W-1:0] syms [ALPHABET_SIZE];
  logic [SYM_W-1:0] front;

  // Configuration port: only the mode register exists.
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_MODE) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENCODE;
    end else if (psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_MODE)) begin
      mode_q <= pwdata_i[0];
    end
  end

  // Input side: a decode position beyond the alphabet clamps to the last entry.
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign key_in     = (mode_q == MODE_DECODE && {1'b0, in_i.data_in} >= AlphaLen) ?
                      LastPos : in_i.data_in;
  assign finish     = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_REDUCE;
          cnt_d   = '0;
        end
      end
      ST_REDUCE: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(LEVELS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Item held while it is looked up.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dec_q <= mode_q;
      key_q <= key_in;
      eob_q <= in_i.end_of_block;
    end
  end

  // Broadcast control: lookup uses the arriving item, the move uses the held one.
  assign ctrl.dec      = accept ? mode_q : dec_q;
  assign ctrl.key      = accept ? key_in : key_q;
  assign ctrl.update   = finish && root.hit;
  assign ctrl.pos      = dec_q ? key_q : root.val;
  assign ctrl.identity = finish && eob_q;
  assign front         = dec_q ? root.val : key_q;

  // Chain of cells; cell 0 takes the symbol being moved to the front.
  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    mtfc_cell #(.INDEX(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i ((i == 0) ? front : syms[(i == 0) ? 0 : i-1]),
      .sym_o  (syms[i]),
      .leaf_o (leaves[i])
    );
  end

  // Leaves beyond the alphabet never hit.
  for (genvar k = ALPHABET_SIZE; k < LEAVES; k++) begin : g_pad
    assign leaves[k] = '0;
  end

  mtfc_reduce u_reduce (
    .clk_i    (clk_i),
    .load_i   (accept),
    .step_i   (state_q == ST_REDUCE),
    .leaves_i (leaves),
    .root_o   (root)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      data_out_q <= root.hit ? root.val : NO_MATCH;
      last_q     <= eob_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = data_out_q;
  assign out_o.last_out = last_q;

endmodule

@@ sv/mtfc_checker.sv @@
// Port-level assertions for the move-to-front codec and their binding.
module mtfc_checker import mtfc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [SYM_W-1:0] data_out_i,
  input logic             last_out_i,
  input logic [31:0]      prdata_i,
  input logic             pready_i
);

  // A stalled result keeps its valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(data_out_i) && $stable(last_out_i))
    else $error("result payload changed while stalled");

  // The lookup is sequential, so an accepted item keeps the input blocked while it runs.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("input accepted again during a lookup");

  // The register port is always ready and reads only the mode bit.
  a_apb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i && (prdata_i[31:1] == 31'd0))
    else $error("register port shows unexpected read data or wait");

endmodule

bind move_to_front_codec mtfc_checker u_mtfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .data_out_i  (out_o.data_out),
  .last_out_i  (out_o.last_out),
  .prdata_i    (prdata_o),
  .pready_i    (pready_o)
);

@@ tb/sv/tb_move_to_front_codec.sv @@
// Self-checking testbench for the move-to-front codec: directed table, random blocks, APB writes.
`timescale 1ns / 100ps

module tb_move_to_front_codec import mtfc_pkg::*;;

  localparam int unsigned ALPHA       = 256;
  localparam int unsigned LATENCY     = 10;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 150;

  // Register addresses: the mode register and a slot that decodes to no register.
  localparam logic [2:0] MODE_ADDR  = {REG_MODE, 2'b00};
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  // One expected result item.
  typedef struct packed {
    logic [SYM_W-1:0] data;
    logic             last;
  } mtf_result_t;

  // One row of the directed table; want is only used when typed is set.
  typedef struct packed {
    logic             mode;
    logic [SYM_W-1:0] data;
    logic             eob;
    logic             typed;
    logic [SYM_W-1:0] want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 19;
  localparam dir_row_t DIR_PLAN [0:DIR_ROWS-1] = '{
    // Encoding from the identity order, extremes and a repeat at the front.
    '{MODE_ENCODE, 8'd0,   1'b0, 1'b1, 8'd0},
    '{MODE_ENCODE, 8'd255, 1'b0, 1'b1, 8'd255},
    '{MODE_ENCODE, 8'd255, 1'b0, 1'b1, 8'd0},
    '{MODE_ENCODE, 8'd0,   1'b0, 1'b1, 8'd1},
    '{MODE_ENCODE, 8'd128, 1'b1, 1'b0, 8'd0},
    '{MODE_ENCODE, 8'd128, 1'b0, 1'b1, 8'd128},
    '{MODE_ENCODE, 8'd1,   1'b0, 1'b0, 8'd0},
    '{MODE_ENCODE, 8'd7,   1'b1, 1'b0, 8'd0},
    // Decoding from the identity order.
    '{MODE_DECODE, 8'd0,   1'b0, 1'b1, 8'd0},
    '{MODE_DECODE, 8'd255, 1'b0, 1'b1, 8'd255},
    '{MODE_DECODE, 8'd0,   1'b0, 1'b1, 8'd255},
    '{MODE_DECODE, 8'd255, 1'b0, 1'b0, 8'd0},
    '{MODE_DECODE, 8'd1,   1'b1, 1'b0, 8'd0},
    // A mode change inside a block keeps the table as it stands.
    '{MODE_ENCODE, 8'd42,  1'b0, 1'b1, 8'd42},
    '{MODE_ENCODE, 8'd42,  1'b0, 1'b1, 8'd0},
    '{MODE_DECODE, 8'd0,   1'b0, 1'b1, 8'd42},
    '{MODE_DECODE, 8'd255, 1'b1, 1'b0, 8'd0},
    '{MODE_DECODE, 8'd200, 1'b1, 1'b1, 8'd200},
    '{MODE_ENCODE, 8'd200, 1'b1, 1'b1, 8'd200}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [2:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  mtfc_in_if  in_bus ();
  mtfc_out_if out_bus ();

  move_to_front_codec #(
    .ALPHABET_SIZE (ALPHA)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_bus),
    .out_o     (out_bus),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  // Predictor state: the symbol order and the mode as the block should hold them.
  logic [SYM_W-1:0] sym_order [0:255];
  logic             cur_mode;
  mtf_result_t      pending_q [$];

  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned blocks_ended;
  int unsigned mode_writes;
  int unsigned cycle_cnt;
  bit          idle_on;
  bit          hold_req;
  int unsigned block_left;
  int unsigned window_base;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Returns the symbol order to identity.
  task automatic order_identity();
    for (int i = 0; i < 256; i++) sym_order[i] = i[SYM_W-1:0];
  endtask

  // Works out the result of one item and moves the chosen entry to the front.
  task automatic mtf_apply(input logic [SYM_W-1:0] sym, input logic eob,
                           output logic [SYM_W-1:0] res);
    int unsigned      pos;
    bit               found;
    logic [SYM_W-1:0] held;
    found = 1'b0;
    pos   = 0;
    if (cur_mode == MODE_ENCODE) begin
      for (int i = 0; i < ALPHA; i++) begin
        if (!found && sym_order[i] == sym) begin
          found = 1'b1;
          pos   = i;
        end
      end
    end else begin
      found = 1'b1;
      pos   = sym;
      if (pos >= ALPHA) pos = ALPHA - 1;
    end
    if (!found) begin
      res = NO_MATCH;
    end else begin
      held = sym_order[pos];
      res  = (cur_mode == MODE_ENCODE) ? pos[SYM_W-1:0] : held;
      for (int i = pos; i > 0; i--) sym_order[i] = sym_order[i-1];
      sym_order[0] = held;
    end
    if (eob) order_identity();
  endtask

  // Offers one item, waits for its acceptance and files the expected result.
  task automatic send_item(input logic [SYM_W-1:0] sym, input logic eob,
                           input bit typed, input logic [SYM_W-1:0] want);
    logic [SYM_W-1:0] pred;
    mtf_result_t      entry;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.data_in      <= sym;
    in_bus.end_of_block <= eob;
    do @(posedge clk_i); while (!in_bus.ready);
    mtf_apply(sym, eob, pred);
    entry.data = typed ? want : pred;
    entry.last = eob;
    pending_q.push_back(entry);
    items_sent++;
    if (eob) blocks_ended++;
    @(negedge clk_i);
  endtask

  // Waits for every expected result, then performs one APB write.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    in_bus.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= addr;
    pwdata_i  <= value;
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    if (addr == MODE_ADDR) begin
      cur_mode = value[0];
      mode_writes++;
    end
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  // Sets the mode; the bits above bit 0 carry random junk.
  task automatic set_mode(input logic mode);
    write_reg(MODE_ADDR, ($urandom() & 32'hFFFF_FFFE) | {31'd0, mode});
  endtask

  // Picks a random data byte: mostly a narrow window so symbols recur.
  function automatic logic [SYM_W-1:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 5) return 8'(window_base + $urandom_range(0, 15));
    if (r <= 7) return 8'($urandom_range(0, 255));
    if (r == 8) return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 3));
  endfunction

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    mtf_result_t exp_item;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch("result item with nothing pending", out_bus.data_out, -1);
      end else begin
        exp_item = pending_q.pop_front();
        if (out_bus.data_out !== exp_item.data)
          report_mismatch("data_out", out_bus.data_out, exp_item.data);
        if (out_bus.last_out !== exp_item.last)
          report_mismatch("last_out", out_bus.last_out, exp_item.last);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_cnt, pending_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stall bursts, and one long hold-off on request.
  initial begin
    int unsigned hold_cnt;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    rst_ni              = 1'b0;
    psel_i              = 1'b0;
    penable_i           = 1'b0;
    pwrite_i            = 1'b0;
    paddr_i             = '0;
    pwdata_i            = '0;
    in_bus.valid        = 1'b0;
    in_bus.data_in      = '0;
    in_bus.end_of_block = 1'b0;
    out_bus.ready       = 1'b0;
    err_cnt             = 0;
    items_sent          = 0;
    results_seen        = 0;
    blocks_ended        = 0;
    mode_writes         = 0;
    cycle_cnt           = 0;
    idle_on             = 1'b1;
    hold_req            = 1'b0;
    block_left          = 0;
    window_base         = 0;
    cur_mode            = MODE_ENCODE;
    order_identity();

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A write to an address with no register must leave the mode alone.
    write_reg(SPARE_ADDR, 32'hFFFF_FFFF);

    // Directed part: the mode register is rewritten only where a row changes it.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_PLAN[r].mode != cur_mode) set_mode(DIR_PLAN[r].mode);
      send_item(DIR_PLAN[r].data, DIR_PLAN[r].eob, DIR_PLAN[r].typed, DIR_PLAN[r].want);
    end

    // Random phases of blocks; the last phase runs without idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      set_mode((p % 2 == 0) ? MODE_DECODE : MODE_ENCODE);
      idle_on = (p != PHASES - 1);
      if (p == 2) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (block_left == 0) begin
          block_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 60);
          window_base = $urandom_range(0, 240);
        end
        block_left--;
        send_item(pick_data(), block_left == 0, 1'b0, '0);
      end
    end

    // Drain, then watch a while longer for stray results.
    in_bus.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (2 * LATENCY) @(negedge clk_i);

    $display("Run covered %0d items in %0d blocks, %0d results checked, %0d mode writes.",
             items_sent, blocks_ended, results_seen, mode_writes);
    $display("Both modes, mid-block mode changes and a long output hold-off were exercised.");
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
